// File: rtl/bblur_pkg.sv
package bblur_pkg;

  // Configuration register layout
  localparam int          CFG_W         = 11;
  localparam logic [10:0] CFG_DIM_RESET = 11'd1024;
  localparam logic        REG_WIDTH     = 1'b0;
  localparam logic        REG_HEIGHT    = 1'b1;

  // Queue depths (powers of two, at least 2)
  localparam int HQ_DEPTH = 4;
  localparam int OQ_DEPTH = 8;

  // Horizontal value travelling from front to back (column index kept apart)
  typedef struct packed {
    logic [7:0] hval;
    logic [9:0] row;
    logic       first_row;
    logic       last_row;
    logic       last_col;
  } hinfo_t;

  // One blurred result
  typedef struct packed {
    logic [7:0] pixel;
    logic [9:0] column;
    logic [9:0] row;
    logic       done;
  } res_t;

endpackage

// File: rtl/bblur_cfg.sv
module bblur_cfg #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [$clog2(MAX_WIDTH)-1:0]  wlast_o,
  output logic [$clog2(MAX_HEIGHT)-1:0] hlast_o,
  output logic                          restart_o
);
  import bblur_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic             wr_en;

  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready;
  assign restart_o = wr_en;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      if (paddr[2] == REG_WIDTH) begin
        width_d = pwdata[CFG_W-1:0];
      end else begin
        height_d = pwdata[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DIM_RESET;
      height_q <= CFG_DIM_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign prdata = (paddr[2] == REG_WIDTH) ? 32'(width_q) : 32'(height_q);

  // Last column / row index after clamping to 1..MAX
  always_comb begin
    if (width_q == '0) begin
      wlast_o = '0;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      wlast_o = CW'(MAX_WIDTH - 1);
    end else begin
      wlast_o = CW'(width_q - 11'd1);
    end
    if (height_q == '0) begin
      hlast_o = '0;
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      hlast_o = RW'(MAX_HEIGHT - 1);
    end else begin
      hlast_o = RW'(height_q - 11'd1);
    end
  end

endmodule

// File: rtl/bblur_queue.sv
module bblur_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr0_en_i,
  input  logic [Width-1:0] wr0_data_i,
  input  logic             wr1_en_i,
  input  logic [Width-1:0] wr1_data_i,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             not_empty_o,
  output logic             room2_o
);

  localparam int AW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr1;
  logic [AW:0]      cnt_q, cnt_d;

  assign wr_ptr1  = wr_ptr_q + AW'(1);
  assign wr_ptr_d = wr_ptr_q + AW'(wr0_en_i) + AW'(wr1_en_i);
  assign rd_ptr_d = rd_ptr_q + AW'(rd_en_i);
  assign cnt_d    = cnt_q + (AW+1)'(wr0_en_i) + (AW+1)'(wr1_en_i) - (AW+1)'(rd_en_i);

  assign rd_data_o   = mem_q[rd_ptr_q];
  assign not_empty_o = (cnt_q != '0);
  assign room2_o     = (cnt_q <= (AW+1)'(Depth - 2));

  always_ff @(posedge clk_i) begin
    if (wr0_en_i) begin
      mem_q[wr_ptr_q] <= wr0_data_i;
    end
    if (wr1_en_i) begin
      mem_q[wr_ptr1] <= wr1_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth))
    else $error("queue count out of range");

  a_wr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr1_en_i |-> wr0_en_i)
    else $error("second write slot used without first");

  a_wr_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr0_en_i |-> room2_o)
    else $error("write into queue without room");

endmodule

// File: rtl/bblur_front.sv
module bblur_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic [$clog2(MAX_WIDTH)-1:0]                   wlast_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]                  hlast_i,
  input  logic                                           restart_i,
  input  logic                                           accept_i,
  input  logic [7:0]                                     pixel_i,
  output logic                                           wr0_en_o,
  output logic [$bits(bblur_pkg::hinfo_t)+$clog2(MAX_WIDTH)-1:0] wr0_data_o,
  output logic                                           wr1_en_o,
  output logic [$bits(bblur_pkg::hinfo_t)+$clog2(MAX_WIDTH)-1:0] wr1_data_o
);
  import bblur_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [7:0]    prev_q, prev_d;
  logic [8:0]    pps_q, pps_d;      // p[x-2] + p[x-1]
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [8:0]    nsum;
  logic [9:0]    sum3;
  logic          col_first, col_last, row_last;
  logic          a_vld, b_vld;
  hinfo_t        a_info, b_info;

  assign nsum      = 9'(prev_q) + 9'(pixel_i);
  assign sum3      = 10'(pps_q) + 10'(nsum);
  assign col_first = (col_q == '0);
  assign col_last  = (col_q == wlast_i);
  assign row_last  = (row_q == hlast_i);

  // Item A: horizontal value of the previous column; item B: last column passes through
  assign a_vld = accept_i & ~col_first;
  assign b_vld = accept_i & col_last;

  always_comb begin
    a_info.hval      = sum3[9:2];
    a_info.row       = 10'(row_q);
    a_info.first_row = (row_q == '0);
    a_info.last_row  = row_last;
    a_info.last_col  = 1'b0;
    b_info           = a_info;
    b_info.hval      = pixel_i;
    b_info.last_col  = 1'b1;
  end

  assign wr0_en_o   = a_vld | b_vld;
  assign wr0_data_o = a_vld ? {a_info, CW'(col_q - CW'(1))} : {b_info, col_q};
  assign wr1_en_o   = a_vld & b_vld;
  assign wr1_data_o = {b_info, col_q};

  always_comb begin
    prev_d = prev_q;
    pps_d  = pps_q;
    col_d  = col_q;
    row_d  = row_q;
    if (accept_i) begin
      prev_d = pixel_i;
      pps_d  = col_first ? {pixel_i, 1'b0} : nsum;
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pps_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      prev_q <= prev_d;
      pps_q  <= pps_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

endmodule

// File: rtl/bblur_back.sv
module bblur_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   h_valid_i,
  input  logic [$bits(bblur_pkg::hinfo_t)+$clog2(MAX_WIDTH)-1:0] h_data_i,
  output logic                                                   h_pop_o,
  input  logic                                                   out_room_i,
  output logic                                                   wr0_en_o,
  output bblur_pkg::res_t                                        wr0_data_o,
  output logic                                                   wr1_en_o,
  output bblur_pkg::res_t                                        wr1_data_o
);
  import bblur_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // Line buffer word: H of the row above, then pair sum of the two rows above
  logic [16:0]   line_mem [MAX_WIDTH];

  hinfo_t        h_info;
  logic [CW-1:0] h_col;

  logic          s2_valid_q, s2_valid_d;
  hinfo_t        s2_info_q;
  logic [CW-1:0] s2_col_q;
  logic [16:0]   rd_data_q;
  logic          fwd_q;
  logic [16:0]   fwd_data_q;

  logic          fire, adv;
  logic [16:0]   line, wdata;
  logic [8:0]    nsum;
  logic [9:0]    vsum;
  res_t          r_up, r_cur;

  assign {h_info, h_col} = h_data_i;

  assign fire       = s2_valid_q & out_room_i;
  assign adv        = h_valid_i & (~s2_valid_q | fire);
  assign h_pop_o    = adv;
  assign s2_valid_d = adv | (s2_valid_q & ~fire);

  // Same-column write in the edge of the read: take the new word directly
  assign line  = fwd_q ? fwd_data_q : rd_data_q;
  assign nsum  = 9'(line[16:9]) + 9'(s2_info_q.hval);
  assign vsum  = 10'(line[8:0]) + 10'(nsum);
  assign wdata = s2_info_q.first_row ? {s2_info_q.hval, s2_info_q.hval, 1'b0}
                                     : {s2_info_q.hval, nsum};

  always_comb begin
    r_up.pixel   = vsum[9:2];
    r_up.column  = 10'(s2_col_q);
    r_up.row     = s2_info_q.row - 10'd1;
    r_up.done    = 1'b0;
    r_cur.pixel  = s2_info_q.hval;
    r_cur.column = 10'(s2_col_q);
    r_cur.row    = s2_info_q.row;
    r_cur.done   = s2_info_q.last_col;
  end

  // Row above first, then current row on the last row
  assign wr0_en_o   = fire & (~s2_info_q.first_row | s2_info_q.last_row);
  assign wr0_data_o = s2_info_q.first_row ? r_cur : r_up;
  assign wr1_en_o   = fire & ~s2_info_q.first_row & s2_info_q.last_row;
  assign wr1_data_o = r_cur;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      line_mem[s2_col_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_data_q <= line_mem[h_col];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_info_q  <= h_info;
      s2_col_q   <= h_col;
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
      if (adv) begin
        fwd_q <= fire & (s2_col_q == h_col);
      end
    end
  end

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !fire |=> s2_valid_q && $stable(s2_col_q) && $stable(s2_info_q))
    else $error("stalled vertical stage lost its item");

endmodule

// File: rtl/binomial_3x3_blur.sv
// Throughput: one pixel per cycle while full is low; on the last row each horizontal value yields two
//   results, so there the single-pop output queue limits the stream to one result per cycle.
// Path: a completing pixel enters the horizontal-value queue, the back registers the line-buffer
//   read, then the vertical add writes the result queue; vertical results trail by one row.
// Reset: counters, queues and config go to their reset values at once; the line buffer
//   needs no clearing since row 0 of every image writes each column before its contents are used.
module binomial_3x3_blur #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Pixel input side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pixel_in_i,
  // Result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  pixel_out_o,
  output logic [9:0]  out_column_o,
  output logic [9:0]  out_row_o,
  output logic        image_done_o
);
  import bblur_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $bits(hinfo_t) + CW;
  localparam int OW = $bits(res_t);

  logic [CW-1:0] wlast;
  logic [RW-1:0] hlast;
  logic          restart;
  logic          accept;

  // Front -> horizontal-value queue
  logic          hq_wr0_en, hq_wr1_en;
  logic [HW-1:0] hq_wr0_data, hq_wr1_data;
  logic          hq_rd_en, hq_not_empty, hq_room2;
  logic [HW-1:0] hq_rd_data;

  // Back -> result queue
  logic          oq_wr0_en, oq_wr1_en;
  res_t          oq_wr0_data, oq_wr1_data;
  logic          oq_not_empty, oq_room2;
  logic [OW-1:0] oq_rd_data;
  res_t          head;

  // Registers and clamped image limits; any write restarts the image
  bblur_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .wlast_o  (wlast),
    .hlast_o  (hlast),
    .restart_o(restart)
  );

  // An input pixel makes up to two horizontal values, so the front needs two free slots
  assign full   = ~hq_room2;
  assign accept = push & ~full;

  // Front: horizontal [1,2,1] pass and raster position tracking
  bblur_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wlast_i   (wlast),
    .hlast_i   (hlast),
    .restart_i (restart),
    .accept_i  (accept),
    .pixel_i   (pixel_in_i),
    .wr0_en_o  (hq_wr0_en),
    .wr0_data_o(hq_wr0_data),
    .wr1_en_o  (hq_wr1_en),
    .wr1_data_o(hq_wr1_data)
  );

  // Decoupling queue between horizontal and vertical passes
  bblur_queue #(
    .Width(HW),
    .Depth(HQ_DEPTH)
  ) u_hq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr0_en_i   (hq_wr0_en),
    .wr0_data_i (hq_wr0_data),
    .wr1_en_i   (hq_wr1_en),
    .wr1_data_i (hq_wr1_data),
    .rd_en_i    (hq_rd_en),
    .rd_data_o  (hq_rd_data),
    .not_empty_o(hq_not_empty),
    .room2_o    (hq_room2)
  );

  // Back: line buffer read, vertical [1,2,1] pass, line buffer write-back
  bblur_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .h_valid_i (hq_not_empty),
    .h_data_i  (hq_rd_data),
    .h_pop_o   (hq_rd_en),
    .out_room_i(oq_room2),
    .wr0_en_o  (oq_wr0_en),
    .wr0_data_o(oq_wr0_data),
    .wr1_en_o  (oq_wr1_en),
    .wr1_data_o(oq_wr1_data)
  );

  // Result queue; the back stalls unless two results fit
  bblur_queue #(
    .Width(OW),
    .Depth(OQ_DEPTH)
  ) u_oq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr0_en_i   (oq_wr0_en),
    .wr0_data_i (oq_wr0_data),
    .wr1_en_i   (oq_wr1_en),
    .wr1_data_i (oq_wr1_data),
    .rd_en_i    (pop & ~empty),
    .rd_data_o  (oq_rd_data),
    .not_empty_o(oq_not_empty),
    .room2_o    (oq_room2)
  );

  assign empty        = ~oq_not_empty;
  assign head         = oq_rd_data;
  assign pixel_out_o  = head.pixel;
  assign out_column_o = head.column;
  assign out_row_o    = head.row;
  assign image_done_o = head.done;

endmodule
